FILE: rtl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants for the target track smoother
// Register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int JUMP_W     = 12;
  localparam int LOST_W     = 8;
  localparam int JUMP_SQ_W  = 2 * JUMP_W;
  localparam int OUT_CW     = 21;
  localparam int OUT_RW     = 20;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_POS_GAIN   = 2'd0;
  localparam logic [1:0] REG_RAD_GAIN   = 2'd1;
  localparam logic [1:0] REG_JUMP_DIST  = 2'd2;
  localparam logic [1:0] REG_LOST_LIMIT = 2'd3;

  localparam logic [GAIN_W-1:0]    POS_GAIN_RST   = 16'd6554;
  localparam logic [GAIN_W-1:0]    RAD_GAIN_RST   = 16'd1311;
  localparam logic [JUMP_W-1:0]    JUMP_DIST_RST  = 12'd100;
  localparam logic [LOST_W-1:0]    LOST_LIMIT_RST = 8'd8;
  localparam logic [JUMP_SQ_W-1:0] JUMP_SQ_RST    = 24'd10000;

  localparam logic [LOST_W-1:0]    LOST_MAX       = 8'd255;

  typedef struct packed {
    logic [GAIN_W-1:0]    position_gain;
    logic [GAIN_W-1:0]    radius_gain;
    logic [JUMP_W-1:0]    jump_distance;
    logic [LOST_W-1:0]    lost_limit;
    logic [JUMP_SQ_W-1:0] jump_sq;      // jump_distance squared, whole pixels
  } cfg_t;

endpackage

FILE: rtl/tte_cfg.sv
// ----------------------------------------------------------------------------
// tte_cfg: configuration registers
// APB-style register file; also keeps the squared jump threshold.
// ----------------------------------------------------------------------------
module tte_cfg import tte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_gain <= POS_GAIN_RST;
      cfg.radius_gain   <= RAD_GAIN_RST;
      cfg.jump_distance <= JUMP_DIST_RST;
      cfg.lost_limit    <= LOST_LIMIT_RST;
      cfg.jump_sq       <= JUMP_SQ_RST;
    end else begin
      // square follows a write in the next cycle; the track stage is further down
      cfg.jump_sq <= JUMP_SQ_W'(cfg.jump_distance) * JUMP_SQ_W'(cfg.jump_distance);
      if (wr_en) begin
        unique case (paddr[3:2])
          REG_POS_GAIN:   cfg.position_gain <= pwdata[GAIN_W-1:0];
          REG_RAD_GAIN:   cfg.radius_gain   <= pwdata[GAIN_W-1:0];
          REG_JUMP_DIST:  cfg.jump_distance <= pwdata[JUMP_W-1:0];
          REG_LOST_LIMIT: cfg.lost_limit    <= pwdata[LOST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POS_GAIN:   prdata = DATA_W'(cfg.position_gain);
      REG_RAD_GAIN:   prdata = DATA_W'(cfg.radius_gain);
      REG_JUMP_DIST:  prdata = DATA_W'(cfg.jump_distance);
      REG_LOST_LIMIT: prdata = DATA_W'(cfg.lost_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: rtl/tte_ema.sv
// ----------------------------------------------------------------------------
// tte_ema: one EMA step
// new = (m*g + s*(65536-g) + 32768) >> 16, computed as s + ((m-s)*g + 32768) >>> 16.
// ----------------------------------------------------------------------------
module tte_ema import tte_pkg::*; #(
  parameter int W = 21
) (
  input  logic [W-1:0]      meas,
  input  logic [W-1:0]      old,
  input  logic [GAIN_W-1:0] gain,
  output logic [W-1:0]      result
);

  localparam int PW = W + GAIN_W + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (GAIN_W - 1);

  logic signed [W:0]    diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] step;
  logic signed [PW-1:0] sum;

  always_comb begin
    diff   = $signed({1'b0, meas}) - $signed({1'b0, old});
    prod   = PW'(diff) * $signed(PW'({1'b0, gain}));
    step   = (prod + HALF) >>> GAIN_W;
    sum    = $signed(PW'(old)) + step;
    // lands between old and meas, so it fits in W bits
    result = sum[W-1:0];
  end

endmodule

FILE: rtl/target_track_ema_smoother.sv
// ----------------------------------------------------------------------------
// target_track_ema_smoother: largest-box tracker with EMA smoothing
// Picks the largest candidate box of each frame and smooths its center/radius.
// ----------------------------------------------------------------------------
// Takes one candidate box per cycle. Three register stages: input capture,
// area compare against the frame's best box, and the track update, which runs
// once per frame with the jump test and EMA side by side, because each frame's
// update reads the track left by the one before. A frame's result passes the
// stage A and stage B registers after its last item is accepted and then shows
// up on m_tvalid. s_tready drops only while a finished frame waits on a held
// output register; otherwise the block sustains one item per clock. Unsigned
// Q(FRAC_BITS) positions throughout.
module target_track_ema_smoother import tte_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8,
  localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((2 * OUT_CW + OUT_RW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // box stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // box_left, box_top, box_width, box_height
  input  logic              s_tuser,   // present
  input  logic              s_tlast,   // last_in_frame
  // track stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // center_x, center_y, radius
  output logic              m_tuser    // track_valid
);

  localparam int CW   = COORD_BITS + FRAC_BITS + 1;
  localparam int RW   = COORD_BITS + FRAC_BITS;
  localparam int AW   = 2 * COORD_BITS;
  localparam int SQW  = 2 * CW + 1;
  localparam int THW  = JUMP_SQ_W + 2 * FRAC_BITS;
  localparam int CMPW = (SQW > THW) ? SQW : THW;

  cfg_t cfg;

  tte_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  logic stall;
  logic adv;

  // stage A: input capture
  logic                  a_valid;
  logic                  a_present;
  logic                  a_last;
  logic [COORD_BITS-1:0] a_left;
  logic [COORD_BITS-1:0] a_top;
  logic [COORD_BITS-1:0] a_w;
  logic [COORD_BITS-1:0] a_h;

  // frame best box
  logic          frame_has_box;
  logic [AW-1:0] best_area;
  logic [CW-1:0] best_cx;
  logic [CW-1:0] best_cy;
  logic [RW-1:0] best_r;

  // stage B: finished frame
  logic          b_valid;
  logic          b_has;
  logic [CW-1:0] b_cx;
  logic [CW-1:0] b_cy;
  logic [RW-1:0] b_r;

  // track
  logic              track_active;
  logic [CW-1:0]     smooth_x;
  logic [CW-1:0]     smooth_y;
  logic [RW-1:0]     smooth_radius;
  logic [LOST_W-1:0] lost_count;

  assign stall    = b_valid && m_tvalid && !m_tready;
  assign adv      = !stall;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_tvalid) begin
      a_present <= s_tuser;
      a_last    <= s_tlast;
      a_left    <= s_tdata[COORD_BITS-1:0];
      a_top     <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      a_w       <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
      a_h       <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    end
  end

  // stage B: area compare, first box wins on ties
  logic [AW-1:0] area;
  logic [CW-1:0] cand_cx;
  logic [CW-1:0] cand_cy;
  logic [RW-1:0] cand_r;
  logic          take;
  logic          sel_has;
  logic [AW-1:0] sel_area;
  logic [CW-1:0] sel_cx;
  logic [CW-1:0] sel_cy;
  logic [RW-1:0] sel_r;

  always_comb begin
    area     = AW'(a_w) * AW'(a_h);
    cand_cx  = (CW'(a_left) << FRAC_BITS) + (CW'(a_w) << (FRAC_BITS - 1));
    cand_cy  = (CW'(a_top) << FRAC_BITS) + (CW'(a_h) << (FRAC_BITS - 1));
    cand_r   = RW'(a_w) << (FRAC_BITS - 1);
    take     = a_present && (!frame_has_box || area > best_area);
    sel_has  = frame_has_box || take;
    sel_area = take ? area    : best_area;
    sel_cx   = take ? cand_cx : best_cx;
    sel_cy   = take ? cand_cy : best_cy;
    sel_r    = take ? cand_r  : best_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_has_box <= 1'b0;
      best_area     <= '0;
      best_cx       <= '0;
      best_cy       <= '0;
      best_r        <= '0;
      b_valid       <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid && a_last;
      if (a_valid) begin
        if (a_last) begin
          frame_has_box <= 1'b0;
          best_area     <= '0;
          best_cx       <= '0;
          best_cy       <= '0;
          best_r        <= '0;
        end else begin
          frame_has_box <= sel_has;
          best_area     <= sel_area;
          best_cx       <= sel_cx;
          best_cy       <= sel_cy;
          best_r        <= sel_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid && a_last) begin
      b_has <= sel_has;
      b_cx  <= sel_cx;
      b_cy  <= sel_cy;
      b_r   <= sel_r;
    end
  end

  // stage C: track update
  logic [CW-1:0]     dx;
  logic [CW-1:0]     dy;
  logic [CMPW-1:0]   dist_sq;
  logic [CMPW-1:0]   thr_sq;
  logic              jump;
  logic [CW-1:0]     ema_x;
  logic [CW-1:0]     ema_y;
  logic [RW-1:0]     ema_r;
  logic              fire;
  logic [LOST_W-1:0] lost_inc;
  logic              valid_next;
  logic              track_active_next;
  logic [CW-1:0]     smooth_x_next;
  logic [CW-1:0]     smooth_y_next;
  logic [RW-1:0]     smooth_radius_next;
  logic [LOST_W-1:0] lost_count_next;

  tte_ema #(.W(CW)) u_ema_x (
    .meas (b_cx), .old (smooth_x), .gain (cfg.position_gain), .result (ema_x)
  );
  tte_ema #(.W(CW)) u_ema_y (
    .meas (b_cy), .old (smooth_y), .gain (cfg.position_gain), .result (ema_y)
  );
  tte_ema #(.W(RW)) u_ema_r (
    .meas (b_r), .old (smooth_radius), .gain (cfg.radius_gain), .result (ema_r)
  );

  always_comb begin
    dx      = (b_cx >= smooth_x) ? b_cx - smooth_x : smooth_x - b_cx;
    dy      = (b_cy >= smooth_y) ? b_cy - smooth_y : smooth_y - b_cy;
    dist_sq = CMPW'(dx) * CMPW'(dx) + CMPW'(dy) * CMPW'(dy);
    thr_sq  = CMPW'(cfg.jump_sq) << (2 * FRAC_BITS);
    jump    = dist_sq > thr_sq;
    fire    = b_valid && adv;

    lost_inc = (lost_count == LOST_MAX) ? lost_count : lost_count + 8'd1;

    valid_next         = 1'b0;
    track_active_next  = track_active;
    smooth_x_next      = smooth_x;
    smooth_y_next      = smooth_y;
    smooth_radius_next = smooth_radius;
    lost_count_next    = lost_inc;

    if (b_has) begin
      valid_next        = 1'b1;
      track_active_next = 1'b1;
      lost_count_next   = '0;
      if (!track_active || jump) begin
        smooth_x_next      = b_cx;
        smooth_y_next      = b_cy;
        smooth_radius_next = b_r;
      end else begin
        smooth_x_next      = ema_x;
        smooth_y_next      = ema_y;
        smooth_radius_next = ema_r;
      end
    end else if (lost_inc < cfg.lost_limit) begin
      valid_next = track_active;
    end else begin
      // track lost
      track_active_next  = 1'b0;
      smooth_x_next      = '0;
      smooth_y_next      = '0;
      smooth_radius_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_active  <= 1'b0;
      smooth_x      <= '0;
      smooth_y      <= '0;
      smooth_radius <= '0;
      lost_count    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (fire) begin
        track_active  <= track_active_next;
        smooth_x      <= smooth_x_next;
        smooth_y      <= smooth_y_next;
        smooth_radius <= smooth_radius_next;
        lost_count    <= lost_count_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tuser <= valid_next;
      if (valid_next) begin
        m_tdata <= OUT_W'({OUT_RW'(smooth_radius_next), OUT_CW'(smooth_y_next),
                           OUT_CW'(smooth_x_next)});
      end else begin
        m_tdata <= '0;
      end
    end
  end

  a_idle_track_zero: assert property (@(posedge clk) disable iff (rst)
    !track_active |-> (smooth_x == '0 && smooth_y == '0 && smooth_radius == '0))
    else $error("track inactive with nonzero smoothed values");

  a_empty_best_zero: assert property (@(posedge clk) disable iff (rst)
    !frame_has_box |-> (best_area == '0 && best_cx == '0 && best_r == '0))
    else $error("best box state set without a box in the frame");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("result without a track carries nonzero data");

  a_box_resets_lost: assert property (@(posedge clk) disable iff (rst)
    (fire && b_has) |=> (lost_count == '0 && track_active && m_tvalid && m_tuser))
    else $error("frame with a box did not refresh the track");

endmodule

FILE: test/track_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_checker: result checker for the target track smoother
// Watches the APB writes, the box stream and the track stream. Each accepted
// box request feeds a cycle-free tracker model, and each frame end queues the
// track it should report. Track results are compared field by field in order.
// ----------------------------------------------------------------------------
module track_checker import tte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [47:0]       s_tdata,   // box_left, box_top, box_width, box_height
  input  logic              s_tuser,   // present
  input  logic              s_tlast,   // last_in_frame
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [63:0]       m_tdata,   // center_x, center_y, radius
  input  logic              m_tuser,   // track_valid
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic              valid;
    logic [OUT_CW-1:0] cx;
    logic [OUT_CW-1:0] cy;
    logic [OUT_RW-1:0] r;
  } track_t;

  track_t expected_tracks[$];

  // register copies
  logic [GAIN_W-1:0] pos_gain, rad_gain;
  logic [JUMP_W-1:0] jump_px;
  logic [LOST_W-1:0] lost_lim;

  // best box of the open frame
  logic        have_box;
  logic [23:0] best_area;
  logic [20:0] best_x, best_y;
  logic [19:0] best_r;

  // track
  logic              tracking;
  logic [20:0]       trk_x, trk_y;
  logic [19:0]       trk_r;
  logic [LOST_W-1:0] miss_cnt;

  task automatic report(input string msg);
    errors++;
    if (errors <= 30) $display("%0t ERROR %s", $time, msg);
  endtask

  // Q0.16 blend, round to nearest with ties up
  function automatic logic [63:0] blend(input logic [63:0] meas, prev,
                                        input logic [GAIN_W-1:0] g);
    return (meas * 64'(g) + prev * (64'd65536 - 64'(g)) + 64'd32768) >> 16;
  endfunction

  function automatic logic [63:0] sq_gap(input logic [63:0] a, b);
    logic [63:0] d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  task automatic step_tracker(input logic pres, input logic [11:0] l, t, w, h,
                              input logic last);
    logic [23:0] area;
    logic [63:0] thr;
    track_t      res;
    area = 24'(w) * 24'(h);
    // strict compare: first box of the frame keeps a tie
    if (pres && (!have_box || area > best_area)) begin
      have_box  = 1'b1;
      best_area = area;
      best_x    = 21'(l) * 21'd256 + 21'(w) * 21'd128;
      best_y    = 21'(t) * 21'd256 + 21'(h) * 21'd128;
      best_r    = 20'(w) * 20'd128;
    end
    if (!last) return;
    res = '0;
    if (have_box) begin
      thr = 64'(jump_px) << 8;
      if (!tracking || sq_gap(best_x, trk_x) + sq_gap(best_y, trk_y) > thr * thr) begin
        trk_x = best_x;
        trk_y = best_y;
        trk_r = best_r;
      end else begin
        trk_x = 21'(blend(best_x, trk_x, pos_gain));
        trk_y = 21'(blend(best_y, trk_y, pos_gain));
        trk_r = 20'(blend(best_r, trk_r, rad_gain));
      end
      tracking  = 1'b1;
      miss_cnt  = '0;
      res.valid = 1'b1;
    end else begin
      if (miss_cnt != LOST_MAX) miss_cnt++;
      if (miss_cnt < lost_lim) begin
        res.valid = tracking;
      end else begin
        tracking = 1'b0;
        trk_x    = '0;
        trk_y    = '0;
        trk_r    = '0;
      end
    end
    if (res.valid) begin
      res.cx = trk_x;
      res.cy = trk_y;
      res.r  = trk_r;
    end
    expected_tracks.push_back(res);
    have_box  = 1'b0;
    best_area = '0;
    best_x    = '0;
    best_y    = '0;
    best_r    = '0;
  endtask

  always @(posedge clk) begin
    track_t got, want;
    if (rst) begin
      pos_gain  = POS_GAIN_RST;
      rad_gain  = RAD_GAIN_RST;
      jump_px   = JUMP_DIST_RST;
      lost_lim  = LOST_LIMIT_RST;
      have_box  = 1'b0;
      best_area = '0;
      best_x    = '0;
      best_y    = '0;
      best_r    = '0;
      tracking  = 1'b0;
      trk_x     = '0;
      trk_y     = '0;
      trk_r     = '0;
      miss_cnt  = '0;
      expected_tracks.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[20:0], m_tdata[41:21], m_tdata[61:42]};
        if (expected_tracks.size() == 0) begin
          report($sformatf("unexpected track: valid=%0b x=%h y=%h r=%h",
                           got.valid, got.cx, got.cy, got.r));
        end else begin
          want = expected_tracks.pop_front();
          if (got.valid !== want.valid)
            report($sformatf("track_valid %0b, want %0b", got.valid, want.valid));
          if (got.cx !== want.cx)
            report($sformatf("center_x %h, want %h", got.cx, want.cx));
          if (got.cy !== want.cy)
            report($sformatf("center_y %h, want %h", got.cy, want.cy));
          if (got.r !== want.r)
            report($sformatf("radius %h, want %h", got.r, want.r));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_POS_GAIN:   pos_gain = pwdata[GAIN_W-1:0];
          REG_RAD_GAIN:   rad_gain = pwdata[GAIN_W-1:0];
          REG_JUMP_DIST:  jump_px  = pwdata[JUMP_W-1:0];
          REG_LOST_LIMIT: lost_lim = pwdata[LOST_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        step_tracker(s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[35:24],
                     s_tdata[47:36], s_tlast);
    end
    pending <= expected_tracks.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the target track smoother
// Drives box frames and register writes with random gaps and output stalls;
// the checker beside the block predicts and compares every track result.
// ----------------------------------------------------------------------------
module tb;
  import tte_pkg::*;

  localparam int WATCHDOG = 2000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [47:0]       s_tdata = '0;   // box_left, box_top, box_width, box_height
  logic              s_tuser = 1'b0; // present
  logic              s_tlast = 1'b0; // last_in_frame
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [63:0]       m_tdata;        // center_x, center_y, radius
  logic              m_tuser;        // track_valid

  int   errors, pending;
  logic calm = 1'b0;       // no new gaps or stalls start while set
  int   cur_lost = 8;
  int   sent_cnt = 0;
  int   tx = 1000, ty = 800, tw = 60, th = 40;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  target_track_ema_smoother DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  track_checker track_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int nudge(input int v, input int span, input int lo, input int hi);
    int n;
    n = v + int'($urandom_range(0, 2 * span)) - span;
    return (n < lo) ? lo : (n > hi) ? hi : n;
  endfunction

  // output stalls, mostly short with a few long ones
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (calm || $urandom_range(0, 99) < 80) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_box(input logic pres, input logic [11:0] l, t, w, h, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= pres;
    s_tlast  <= last;
    s_tdata  <= {h, w, t, l};
    do @(posedge clk); while (!s_tready);
    sent_cnt++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop the stream, drain every pending track and let the pipeline empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // upper bits carry junk; the registers keep only their own width
  task automatic set_regs(input logic [15:0] pg, rg, input logic [11:0] jd,
                          input logic [7:0] ll);
    settle();
    reg_write(REG_POS_GAIN, {16'($urandom), pg});
    reg_write(REG_RAD_GAIN, {16'($urandom), rg});
    reg_write(REG_JUMP_DIST, {20'($urandom), jd});
    reg_write(REG_LOST_LIMIT, {24'($urandom), ll});
    cur_lost = int'(ll);
  endtask

  task automatic empty_frames(input int n);
    repeat (n) put_box(1'b0, 12'($urandom), 12'($urandom), 12'($urandom),
                       12'($urandom), 1'b1);
  endtask

  task automatic noise_frame();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      put_box(1'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
              12'($urandom), i == n - 1);
  endtask

  // one target that mostly drifts between frames, plus absent, equal-area or smaller distractors
  task automatic tracked_frame();
    int n, tpos, jit, r;
    logic last;
    r = $urandom_range(0, 99);
    jit = (r < 80) ? 4 : (r < 95) ? 40 : 300;
    if ($urandom_range(0, 19) == 0) begin
      tx = $urandom_range(0, 4095);
      ty = $urandom_range(0, 4095);
    end else begin
      tx = nudge(tx, jit, 0, 4095);
      ty = nudge(ty, jit, 0, 4095);
    end
    tw = nudge(tw, 2, 1, 600);
    th = nudge(th, 2, 1, 600);
    n = $urandom_range(1, 4);
    tpos = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1);
      r = $urandom_range(0, 99);
      if (i == tpos)
        put_box(1'b1, 12'(tx), 12'(ty), 12'(tw), 12'(th), last);
      else if (r < 10)
        put_box(1'b0, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), last);
      else if (r < 25)
        put_box(1'b1, 12'($urandom), 12'($urandom), 12'(th), 12'(tw), last); // equal area
      else
        put_box(1'b1, 12'($urandom), 12'($urandom), 12'($urandom_range(1, tw)),
                12'($urandom_range(0, th - 1)), last);
    end
  endtask

  task automatic run_phase(input int n_items);
    int stop, r;
    stop = sent_cnt + n_items;
    while (sent_cnt < stop) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 8)
        empty_frames($urandom_range(1, (cur_lost > 10) ? 4 : cur_lost + 2));
      else if (r < 14)
        noise_frame();
      else
        tracked_frame();
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset register values: load, hold, exact jump threshold, tie, area zero
    put_box(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    empty_frames(1);
    put_box(1'b1, 12'd1000, 12'd1000, 12'd0, 12'd0, 1'b1);
    put_box(1'b1, 12'd1100, 12'd1000, 12'd0, 12'd0, 1'b1);  // jump equals threshold
    put_box(1'b1, 12'd500, 12'd500, 12'd10, 12'd20, 1'b0);
    put_box(1'b1, 12'd600, 12'd600, 12'd20, 12'd10, 1'b0);
    put_box(1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    put_box(1'b1, 12'd700, 12'd700, 12'd5, 12'd5, 1'b1);
    put_box(1'b1, 12'd506, 12'd511, 12'd12, 12'd20, 1'b1);
    put_box(1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    put_box(1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
    empty_frames(9);                                        // held, then dropped
    put_box(1'b1, 12'd4095, 12'd0, 12'd1, 12'd4095, 1'b1);

    set_regs(16'hFFFF, 16'hFFFF, 12'd4095, 8'd255);
    tracked_frame();
    empty_frames(258);                                      // miss count saturates
    run_phase(170);

    set_regs(16'd0, 16'd0, 12'd0, 8'd1);
    run_phase(170);

    set_regs(16'($urandom), 16'($urandom), 12'($urandom_range(0, 300)),
             8'($urandom_range(1, 255)));
    run_phase(170);

    set_regs(16'd32768, 16'($urandom), 12'd20, 8'd0);
    run_phase(170);

    set_regs(16'($urandom), 16'($urandom), 12'($urandom), 8'($urandom_range(2, 6)));
    run_phase(170);

    set_regs(16'd1, 16'd65534, 12'd200, 8'd3);
    run_phase(170);

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
